// ----- hdl/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_HOLDS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_HOLDS(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif

`endif

// ----- hdl/spow_pkg.sv -----
`default_nettype none
package spow_pkg;

  localparam int NONCE_W  = 54;
  localparam int STEP_W   = 11;
  localparam int HASH_W   = 32;
  localparam int CFG_W    = 64;
  localparam int DIFF_W   = 6;
  localparam int NONCE_DIGITS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF  = 2;

  localparam logic [NONCE_W-1:0] LIMIT_RESET = 54'd10000000000000000;
  localparam logic [DIFF_W-1:0]  DIFF_MAX    = 6'd32;
  localparam logic [6:0]         LAST_ROUND  = 7'd79;

  localparam logic [31:0] H0_INIT = 32'h67452301;
  localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
  localparam logic [31:0] H2_INIT = 32'h98BADCFE;
  localparam logic [31:0] H3_INIT = 32'h10325476;
  localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

  typedef enum logic [1:0] {
    CFG_PROBLEM_FIRST  = 2'd0,
    CFG_PROBLEM_SECOND = 2'd1,
    CFG_DIFFICULTY     = 2'd2,
    CFG_SEARCH_LIMIT   = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_START,
    B_ROUND,
    B_CHECK,
    B_DONE
  } back_state_t;

  typedef struct packed {
    logic [NONCE_W-1:0] start_nonce;
    logic [STEP_W-1:0]  nonce_step;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic [NONCE_W-1:0] nonce;
    logic [HASH_W-1:0]  first_hash_word;
  } out_item_t;

  function automatic logic [31:0] round_k(input logic [6:0] t);
    logic [31:0] k;
    if (t < 7'd20) k = 32'h5A827999;
    else if (t < 7'd40) k = 32'h6ED9EBA1;
    else if (t < 7'd60) k = 32'h8F1BBCDC;
    else k = 32'hCA62C1D6;
    return k;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (t < 7'd20) f = (b & c) | (~b & d);
    else if (t < 7'd40) f = b ^ c ^ d;
    else if (t < 7'd60) f = (b & c) | (b & d) | (c & d);
    else f = b ^ c ^ d;
    return f;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/spow_queue.sv -----
`default_nettype none
module spow_queue
  import spow_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic                  valid,
  output logic                  full,
  output logic [WIDTH-1:0]      data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign valid = (count != '0);
  assign full  = (count == CW'(DEPTH));
  assign data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && valid) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(push && !full) - CW'(pop && valid);
    end
  end

endmodule
`default_nettype wire

// ----- hdl/spow_front.sv -----
`default_nettype none
module spow_front
  import spow_pkg::*;
#(
  parameter int NONCE_DIGITS = NONCE_DIGITS_DEF,
  parameter int QW = NONCE_W + STEP_W + 8 * NONCE_DIGITS
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire in_item_t      in_data,
  input  wire logic          q_full,
  output logic               q_push,
  output logic [QW-1:0]      q_data
);

  localparam int DW = 4 * NONCE_DIGITS;
  localparam logic [5:0] CNT_LAST = 6'(NONCE_W - 1);

  front_state_t       state, state_next;
  logic [NONCE_W-1:0] start_keep;
  logic [STEP_W-1:0]  step_keep;
  logic [NONCE_W-1:0] start_sh;
  logic [NONCE_W-1:0] step_sh;
  logic [DW-1:0]      start_bcd;
  logic [DW-1:0]      step_bcd;
  logic [5:0]         cnt;
  logic               accept;

  function automatic logic [DW-1:0] dabble(input logic [DW-1:0] v, input logic b);
    logic [DW-1:0] x;
    x = v;
    for (int i = 0; i < NONCE_DIGITS; i++) begin
      if (x[4*i +: 4] >= 4'd5) x[4*i +: 4] = x[4*i +: 4] + 4'd3;
    end
    return {x[DW-2:0], b};
  endfunction

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: if (in_valid) state_next = F_CONV;
      F_CONV: if (cnt == CNT_LAST) state_next = F_PUSH;
      F_PUSH: if (!q_full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != F_IDLE);
    accept   = (state == F_IDLE) && in_valid;
    q_push   = (state == F_PUSH) && !q_full;
  end

  assign q_data = {start_keep, step_keep, start_bcd, step_bcd};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      start_keep <= in_data.start_nonce;
      step_keep  <= (in_data.nonce_step == '0) ? STEP_W'(1) : in_data.nonce_step;
      start_sh   <= in_data.start_nonce;
      step_sh    <= (in_data.nonce_step == '0) ? NONCE_W'(1)
                                               : NONCE_W'(in_data.nonce_step);
      start_bcd  <= '0;
      step_bcd   <= '0;
      cnt        <= '0;
    end else if (state == F_CONV) begin
      start_bcd <= dabble(start_bcd, start_sh[NONCE_W-1]);
      step_bcd  <= dabble(step_bcd, step_sh[NONCE_W-1]);
      start_sh  <= {start_sh[NONCE_W-2:0], 1'b0};
      step_sh   <= {step_sh[NONCE_W-2:0], 1'b0};
      cnt       <= cnt + 6'd1;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/spow_back.sv -----
`default_nettype none
module spow_back
  import spow_pkg::*;
#(
  parameter int NONCE_DIGITS = NONCE_DIGITS_DEF,
  parameter int QW = NONCE_W + STEP_W + 8 * NONCE_DIGITS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_valid,
  output logic                    q_pop,
  input  wire logic [QW-1:0]      q_data,
  input  wire logic [CFG_W-1:0]   problem_first_half,
  input  wire logic [CFG_W-1:0]   problem_second_half,
  input  wire logic [HASH_W-1:0]  hash_mask,
  input  wire logic [NONCE_W-1:0] search_limit,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output out_item_t               out_data
);

  localparam int DW  = 4 * NONCE_DIGITS;
  localparam int DCW = $clog2(NONCE_DIGITS + 1);
  localparam int MSG_BYTES = 32 + NONCE_DIGITS;
  localparam logic [15:0] MSG_BITS = 16'(MSG_BYTES * 8);

  back_state_t        state, state_next;
  logic [NONCE_W-1:0] n;
  logic [STEP_W-1:0]  step;
  logic [DW-1:0]      nbcd;
  logic [DW-1:0]      sbcd;
  logic [DCW-1:0]     dcnt;
  logic               carry;
  logic [31:0]        ra, rb, rc, rd, re;
  logic [31:0]        win [16];
  logic [6:0]         rnd;
  logic               res_found;
  logic [NONCE_W-1:0] res_nonce;
  logic [HASH_W-1:0]  res_hash;

  logic [7:0]         blk [64];
  logic [31:0]        wcur;
  logic [31:0]        wmix;
  logic [31:0]        tmp;
  logic [31:0]        h0;
  logic               hit;
  logic [NONCE_W:0]   sum;
  logic               at_limit;
  logic               sum_over;
  logic               out_free;
  logic               out_load;
  logic [4:0]         dsum;

  always_comb begin
    for (int p = 0; p < 64; p++) begin
      if (p < 8) blk[p] = problem_first_half[63-8*p -: 8];
      else if (p < 16) blk[p] = problem_second_half[63-8*(p-8) -: 8];
      else if (p < 16 + NONCE_DIGITS) blk[p] = {4'h3, nbcd[4*(NONCE_DIGITS-1-(p-16)) +: 4]};
      else if (p < 24 + NONCE_DIGITS) blk[p] = problem_first_half[63-8*(p-16-NONCE_DIGITS) -: 8];
      else if (p < MSG_BYTES) blk[p] = problem_second_half[63-8*(p-24-NONCE_DIGITS) -: 8];
      else if (p == MSG_BYTES) blk[p] = 8'h80;
      else if (p == 62) blk[p] = MSG_BITS[15:8];
      else if (p == 63) blk[p] = MSG_BITS[7:0];
      else blk[p] = 8'h00;
    end
  end

  always_comb begin
    wmix = win[13] ^ win[8] ^ win[2] ^ win[0];
    wcur = (rnd < 7'd16) ? win[0] : {wmix[30:0], wmix[31]};
    tmp  = {ra[26:0], ra[31:27]} + round_f(rnd, rb, rc, rd) + re + round_k(rnd) + wcur;
    h0   = H0_INIT + ra;
    hit  = ((h0 & hash_mask) == '0);
    sum  = {1'b0, n} + (NONCE_W+1)'(step);
    at_limit = (n >= search_limit);
    sum_over = (sum >= {1'b0, search_limit});
    dsum = {1'b0, nbcd[3:0]} + {1'b0, sbcd[3:0]} + 5'(carry);
    out_free = !out_valid || !out_stall;
  end

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:  if (q_valid) state_next = B_START;
      B_START: state_next = at_limit ? B_DONE : B_ROUND;
      B_ROUND: if (rnd == LAST_ROUND) state_next = B_CHECK;
      B_CHECK: state_next = (hit || sum_over) ? B_DONE : B_START;
      B_DONE:  if (out_free) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = (state == B_IDLE) && q_valid;
    out_load = (state == B_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.found           <= res_found;
      out_data.nonce           <= res_nonce;
      out_data.first_hash_word <= res_hash;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (q_valid) begin
          {n, step, nbcd, sbcd} <= q_data;
        end
      end
      B_START: begin
        if (at_limit) begin
          res_found <= 1'b0;
          res_nonce <= '0;
          res_hash  <= '0;
        end else begin
          for (int i = 0; i < 16; i++) begin
            win[i] <= {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
          end
          ra    <= H0_INIT;
          rb    <= H1_INIT;
          rc    <= H2_INIT;
          rd    <= H3_INIT;
          re    <= H4_INIT;
          rnd   <= '0;
          dcnt  <= '0;
          carry <= 1'b0;
        end
      end
      B_ROUND: begin
        re  <= rd;
        rd  <= rc;
        rc  <= {rb[1:0], rb[31:2]};
        rb  <= ra;
        ra  <= tmp;
        for (int i = 0; i < 15; i++) begin
          win[i] <= win[i+1];
        end
        win[15] <= wcur;
        rnd <= rnd + 7'd1;
        if (dcnt < DCW'(NONCE_DIGITS)) begin
          if (dsum >= 5'd10) begin
            nbcd  <= {4'(dsum - 5'd10), nbcd[DW-1:4]};
            carry <= 1'b1;
          end else begin
            nbcd  <= {dsum[3:0], nbcd[DW-1:4]};
            carry <= 1'b0;
          end
          sbcd <= {sbcd[3:0], sbcd[DW-1:4]};
          dcnt <= dcnt + 1'b1;
        end
      end
      B_CHECK: begin
        if (hit) begin
          res_found <= 1'b1;
          res_nonce <= n;
          res_hash  <= h0;
        end else if (sum_over) begin
          res_found <= 1'b0;
          res_nonce <= '0;
          res_hash  <= '0;
        end else begin
          n <= sum[NONCE_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- hdl/sha1_proof_of_work_search.sv -----
// Searches nonces start, start+step, ... below the search limit for the first one whose
// SHA-1 digest of problem||digits||problem has its top difficulty bits of word H0 clear,
// and returns one result item per request. The front stage converts the start nonce and
// step to decimal and queues the request; the back stage runs one SHA-1 round per cycle,
// so each candidate takes a block load, 80 rounds and a check, and a request tries on
// average 2^difficulty candidates (none when the start nonce is already at or past the
// limit). Front conversion of the next request overlaps the current search.
`default_nettype none
`include "assert_macros.svh"
module sha1_proof_of_work_search
  import spow_pkg::*;
#(
  parameter int NONCE_DIGITS = NONCE_DIGITS_DEF,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_item_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_item_t             out_data
);

  localparam int QW = NONCE_W + STEP_W + 8 * NONCE_DIGITS;

  logic [CFG_W-1:0]   problem_first_half;
  logic [CFG_W-1:0]   problem_second_half;
  logic [DIFF_W-1:0]  difficulty;
  logic [NONCE_W-1:0] search_limit;
  logic [DIFF_W-1:0]  diff_clamped;
  logic [HASH_W-1:0]  hash_mask;

  logic               q_push;
  logic [QW-1:0]      q_push_data;
  logic               q_pop;
  logic               q_valid;
  logic               q_full;
  logic [QW-1:0]      q_data;

  logic               res_miss_clean;
  logic               res_hit_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      problem_first_half  <= '0;
      problem_second_half <= '0;
      difficulty          <= '0;
      search_limit        <= LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_PROBLEM_FIRST:  problem_first_half  <= cfg_data;
        CFG_PROBLEM_SECOND: problem_second_half <= cfg_data;
        CFG_DIFFICULTY:     difficulty          <= cfg_data[DIFF_W-1:0];
        CFG_SEARCH_LIMIT:   search_limit        <= cfg_data[NONCE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign diff_clamped = (difficulty > DIFF_MAX) ? DIFF_MAX : difficulty;
  assign hash_mask    = ~({HASH_W{1'b1}} >> diff_clamped);

  spow_front #(
    .NONCE_DIGITS (NONCE_DIGITS),
    .QW           (QW)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_push_data)
  );

  spow_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .valid     (q_valid),
    .full      (q_full),
    .data      (q_data)
  );

  spow_back #(
    .NONCE_DIGITS (NONCE_DIGITS),
    .QW           (QW)
  ) u_back (
    .clk                 (clk),
    .rst                 (rst),
    .q_valid             (q_valid),
    .q_pop               (q_pop),
    .q_data              (q_data),
    .problem_first_half  (problem_first_half),
    .problem_second_half (problem_second_half),
    .hash_mask           (hash_mask),
    .search_limit        (search_limit),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_data            (out_data)
  );

  assign res_miss_clean = (out_data.nonce == '0) && (out_data.first_hash_word == '0);
  assign res_hit_ok     = ((out_data.first_hash_word & hash_mask) == '0) &&
                          (out_data.nonce < search_limit);

  `ASSERT_HOLDS(a_miss_zero, clk, rst, out_valid && !out_data.found |-> res_miss_clean)
  `ASSERT_HOLDS(a_hit_ok, clk, rst, out_valid && out_data.found |-> res_hit_ok)
  `ASSERT_NEVER(a_no_overflow, clk, rst, q_push && q_full)

endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
module testbench;
  import spow_pkg::*;

  localparam int LONG_HOLD = 4000;
  localparam int DRAIN_CYCLES = 300;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [1:0]       cfg_index = CFG_PROBLEM_FIRST;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_item_t         in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_data;

  logic [63:0]        problem_hi = '0;
  logic [63:0]        problem_lo = '0;
  logic [DIFF_W-1:0]  leading_zeros = '0;
  logic [NONCE_W-1:0] nonce_limit = LIMIT_RESET;

  out_item_t pending_results[$];
  int        error_count = 0;
  bit        calm = 1'b0;
  bit        long_hold = 1'b0;

  sha1_proof_of_work_search i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] digest_h0(input logic [NONCE_W-1:0] nonce);
    logic [7:0]  blk[64];
    logic [31:0] w[16];
    logic [31:0] a, b, c, d, e, f, k, tmp, wt;
    longint unsigned v;
    v = nonce;
    for (int i = 0; i < 64; i++) blk[i] = 8'h00;
    for (int i = 0; i < 8; i++) begin
      blk[i] = problem_hi[63-8*i -: 8];
      blk[8+i] = problem_lo[63-8*i -: 8];
      blk[32+i] = problem_hi[63-8*i -: 8];
      blk[40+i] = problem_lo[63-8*i -: 8];
    end
    for (int i = 15; i >= 0; i--) begin
      blk[16+i] = 8'h30 + 8'(v % 10);
      v = v / 10;
    end
    blk[48] = 8'h80;
    blk[62] = 8'h01;
    blk[63] = 8'h80;
    for (int i = 0; i < 16; i++) w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    a = H0_INIT; b = H1_INIT; c = H2_INIT; d = H3_INIT; e = H4_INIT;
    for (int t = 0; t < 80; t++) begin
      if (t < 16) wt = w[t];
      else begin
        wt = rotl(w[(t+13)&15] ^ w[(t+8)&15] ^ w[(t+2)&15] ^ w[t&15], 1);
        w[t&15] = wt;
      end
      if (t < 20) begin f = (b & c) | (~b & d); k = 32'h5A827999; end
      else if (t < 40) begin f = b ^ c ^ d; k = 32'h6ED9EBA1; end
      else if (t < 60) begin f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC; end
      else begin f = b ^ c ^ d; k = 32'hCA62C1D6; end
      tmp = rotl(a, 5) + f + e + k + wt;
      e = d; d = c; c = rotl(b, 30); b = a; a = tmp;
    end
    return H0_INIT + a;
  endfunction

  function automatic out_item_t search_nonce(input in_item_t req);
    out_item_t       res;
    longint unsigned n, stride;
    int              dz;
    logic [31:0]     mask, h0;
    res = '0;
    n = req.start_nonce;
    stride = (req.nonce_step == 0) ? 1 : req.nonce_step;
    dz = (leading_zeros > DIFF_MAX) ? 32 : leading_zeros;
    mask = (dz == 0) ? 32'h0 : (32'hFFFFFFFF << (32 - dz));
    while (n < nonce_limit) begin
      h0 = digest_h0(n[NONCE_W-1:0]);
      if ((h0 & mask) == 0) begin
        res.found = 1'b1;
        res.nonce = n[NONCE_W-1:0];
        res.first_hash_word = h0;
        break;
      end
      n += stride;
    end
    return res;
  endfunction

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  task automatic configure(input logic [63:0] hi, input logic [63:0] lo,
                           input logic [DIFF_W-1:0] dz, input logic [NONCE_W-1:0] lim);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    write_reg(CFG_PROBLEM_FIRST, hi);
    write_reg(CFG_PROBLEM_SECOND, lo);
    write_reg(CFG_DIFFICULTY, CFG_W'(dz));
    write_reg(CFG_SEARCH_LIMIT, CFG_W'(lim));
    cfg_we <= 1'b0;
    problem_hi = hi;
    problem_lo = lo;
    leading_zeros = dz;
    nonce_limit = lim;
  endtask

  task automatic send_item(input logic [NONCE_W-1:0] start, input logic [STEP_W-1:0] stride);
    int gap;
    in_item_t req;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.start_nonce = start;
    req.nonce_step = stride;
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(search_nonce(req));
  endtask

  task automatic end_phase();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [NONCE_W-1:0] rand_nonce();
    return NONCE_W'({$urandom, $urandom});
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected item found=%0b nonce=%0d hash=%h", $realtime,
                 out_data.found, out_data.nonce, out_data.first_hash_word);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.found !== want.found) begin
          $display("%0t: found expected %0b actual %0b", $realtime, want.found, out_data.found);
          error_count++;
        end
        if (out_data.nonce !== want.nonce) begin
          $display("%0t: nonce expected %0d actual %0d", $realtime, want.nonce, out_data.nonce);
          error_count++;
        end
        if (out_data.first_hash_word !== want.first_hash_word) begin
          $display("%0t: hash expected %h actual %h", $realtime,
                   want.first_hash_word, out_data.first_hash_word);
          error_count++;
        end
      end
    end
  end

  initial begin
    int w;
    forever begin
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold = 1'b0;
      end
      w = calm ? 0 : $urandom_range(0, 5);
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
    end
  end

  task automatic test_reset_defaults();
    send_item(0, 1);
    send_item(NONCE_W'(64'd9999999999999999), 1);
    send_item('1, 1);
    send_item(123, 0);
    send_item(77, '1);
    end_phase();
  endtask

  task automatic test_hard_difficulty();
    configure('1, '1, DIFF_MAX, 1000);
    send_item(990, 1);
    send_item(1000, 1);
    send_item(900, 2047);
    end_phase();
    configure('0, '1, '1, 20);
    send_item(5, 1);
    send_item(0, 0);
    end_phase();
  endtask

  task automatic test_limit_and_wide_nonce();
    configure(64'h0123456789ABCDEF, 64'hFEDCBA9876543210, 6'd9, 50);
    send_item(0, 7);
    send_item(49, 1);
    end_phase();
    configure('1, '0, 6'd0, '1);
    send_item('1 - 2, 1);
    send_item('1, 1);
    end_phase();
    configure('1, '0, 6'd2, '1);
    send_item('1 - 40, 1);
    send_item(NONCE_W'(64'd10000000000000123), 3);
    end_phase();
    configure('0, '0, 6'd1, 1);
    send_item(0, 1);
    send_item(1, 1);
    end_phase();
  endtask

  task automatic test_random_search();
    logic [NONCE_W-1:0] start, lim;
    logic [STEP_W-1:0]  stride;
    for (int phase = 0; phase < 10; phase++) begin
      calm = (phase == 3);
      lim = ($urandom_range(0, 2) == 0) ? NONCE_W'($urandom_range(1, 20000)) : LIMIT_RESET;
      if ($urandom_range(0, 4) == 0) lim = rand_nonce() | 1;
      configure({$urandom, $urandom}, {$urandom, $urandom},
                DIFF_W'($urandom_range(0, 6)), lim);
      for (int i = 0; i < 10; i++) begin
        stride = STEP_W'($urandom_range(0, 2047));
        case ($urandom_range(0, 3))
          0: start = NONCE_W'($urandom_range(0, 30000));
          1: start = (lim > 300) ? lim - NONCE_W'($urandom_range(1, 300)) : 0;
          2: start = NONCE_W'(64'd9999999999999999) - NONCE_W'($urandom_range(0, 100000));
          default: start = rand_nonce();
        endcase
        send_item(start, stride);
      end
      end_phase();
    end
    calm = 1'b0;
  endtask

  task automatic test_output_backpressure();
    configure({$urandom, $urandom}, {$urandom, $urandom}, 6'd0, LIMIT_RESET);
    long_hold = 1'b1;
    for (int i = 0; i < 12; i++) send_item(rand_nonce(), STEP_W'($urandom_range(0, 2047)));
    end_phase();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_hard_difficulty();
    test_limit_and_wide_nonce();
    test_output_backpressure();
    test_random_search();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
